FILE: src/ows_pkg.sv
// Package for the ROM search engine: operation and status codes, search
// constants and the transaction payload types. No dependencies.
package ows_pkg;

  // Search geometry
  localparam int unsigned RomBits     = 64;
  localparam int unsigned PosWidth    = 7;
  localparam int unsigned IdxWidth    = 6;
  localparam int unsigned FamWidth    = 4;
  localparam logic [PosWidth-1:0] FamilyLimit = 7'd9;
  localparam logic [PosWidth-1:0] EndPosition = 7'd65;
  localparam logic [PosWidth-1:0] RomBitsPos  = 7'd64;
  localparam logic [PosWidth-1:0] FirstPos    = 7'd1;

  typedef enum logic [1:0] {
    OP_START      = 2'd0,
    OP_BIT_PAIR   = 2'd1,
    OP_RESET      = 2'd2,
    OP_TARGET_FAM = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_SEND_F0   = 3'd1,
    ST_NO_DEVICE = 3'd2,
    ST_CONTINUE  = 3'd3,
    ST_FOUND     = 3'd4,
    ST_FAIL      = 3'd5,
    ST_BOTH_ONES = 3'd6,
    ST_RESET     = 3'd7
  } status_t;

  typedef struct packed {
    op_t        operation;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
    logic [7:0] target_family;
  } item_t;

  typedef struct packed {
    status_t               status;
    logic                  direction;
    logic [RomBits-1:0]    rom_address;
    logic [FamWidth-1:0]   family_discrepancy;
  } result_t;

endpackage

FILE: src/ows_if.sv
// Valid/ready channel interfaces for search operations and search results.
// Depends on ows_pkg for the payload types.
interface ows_item_if import ows_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ows_result_if import ows_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/one_wire_rom_search_top.sv
// ROM search engine: one operation per transaction, one result per operation.
// The result register loads on accept and frees as its result is taken.
// Throughput: 1 operation per cycle while results are taken; else it stalls.
// Reset (rst, synchronous): equals a search reset, no result pending.
// Depends on ows_pkg and the channel interfaces in ows_if.sv.
module one_wire_rom_search_top import ows_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ows_item_if.sink     item,
  ows_result_if.source result
);

  // Search state
  logic [RomBits-1:0]  rom_code, rom_code_next;
  logic [PosWidth-1:0] last_discrepancy, last_discrepancy_next;
  logic [FamWidth-1:0] last_family_disc, last_family_disc_next;
  logic                last_device_seen, last_device_seen_next;
  logic [PosWidth-1:0] bit_position, bit_position_next;
  logic [PosWidth-1:0] last_zero_position, last_zero_position_next;
  logic                searching, searching_next;

  // Result register
  logic    result_valid;
  result_t result_data, result_data_next;

  logic                accept;
  logic [PosWidth-1:0] pos_m1;
  logic [IdxWidth-1:0] bit_idx;
  logic [PosWidth-1:0] pos_inc;
  logic                dir;

  assign accept     = item.valid && item.ready;
  assign item.ready = !result_valid || result.ready;
  assign result.valid = result_valid;
  assign result.data  = result_data;

  assign pos_m1  = bit_position - FirstPos;
  assign bit_idx = pos_m1[IdxWidth-1:0];
  assign pos_inc = bit_position + FirstPos;

  // Work out one operation against the current search state
  always_comb begin
    rom_code_next           = rom_code;
    last_discrepancy_next   = last_discrepancy;
    last_family_disc_next   = last_family_disc;
    last_device_seen_next   = last_device_seen;
    bit_position_next       = bit_position;
    last_zero_position_next = last_zero_position;
    searching_next          = searching;
    result_data_next        = '0;
    result_data_next.status = ST_IGNORED;
    dir                     = 1'b0;

    case (item.data.operation)
      OP_START: begin
        if (last_device_seen || !item.data.presence) begin
          rom_code_next           = '0;
          last_discrepancy_next   = '0;
          last_family_disc_next   = '0;
          last_device_seen_next   = 1'b0;
          bit_position_next       = FirstPos;
          last_zero_position_next = '0;
          searching_next          = 1'b0;
          result_data_next.status = ST_NO_DEVICE;
        end else begin
          searching_next          = 1'b1;
          bit_position_next       = FirstPos;
          last_zero_position_next = '0;
          result_data_next.status = ST_SEND_F0;
        end
      end
      OP_BIT_PAIR: begin
        if (!searching) begin
          result_data_next.status = ST_IGNORED;
        end else if (item.data.id_bit && item.data.complement_bit) begin
          rom_code_next           = '0;
          last_discrepancy_next   = '0;
          last_family_disc_next   = '0;
          last_device_seen_next   = 1'b0;
          bit_position_next       = FirstPos;
          last_zero_position_next = '0;
          searching_next          = 1'b0;
          result_data_next.status = ST_BOTH_ONES;
        end else begin
          // Pick the direction: bus decides, else follow the discrepancy
          if (item.data.id_bit != item.data.complement_bit) begin
            dir = item.data.id_bit;
          end else begin
            if (bit_position < last_discrepancy) begin
              dir = rom_code[bit_idx];
            end else begin
              dir = (bit_position == last_discrepancy);
            end
            if (!dir) begin
              last_zero_position_next = bit_position;
              if (bit_position < FamilyLimit) begin
                last_family_disc_next = bit_position[FamWidth-1:0];
              end
            end
          end
          rom_code_next[bit_idx] = dir;
          bit_position_next      = pos_inc;
          result_data_next.direction = dir;
          // Finish the pass after the last bit
          if (pos_inc >= EndPosition || bit_position >= RomBitsPos) begin
            last_discrepancy_next = last_zero_position_next;
            if (last_zero_position_next == '0) begin
              last_device_seen_next = 1'b1;
            end
            searching_next = 1'b0;
            if (rom_code_next[7:0] == 8'd0) begin
              rom_code_next           = '0;
              last_discrepancy_next   = '0;
              last_family_disc_next   = '0;
              last_device_seen_next   = 1'b0;
              bit_position_next       = FirstPos;
              last_zero_position_next = '0;
              result_data_next.status = ST_FAIL;
            end else begin
              result_data_next.rom_address = rom_code_next;
              result_data_next.status      = ST_FOUND;
            end
          end else begin
            result_data_next.status = ST_CONTINUE;
          end
        end
      end
      OP_RESET: begin
        rom_code_next           = '0;
        last_discrepancy_next   = '0;
        last_family_disc_next   = '0;
        last_device_seen_next   = 1'b0;
        bit_position_next       = FirstPos;
        last_zero_position_next = '0;
        searching_next          = 1'b0;
        result_data_next.status = ST_RESET;
      end
      OP_TARGET_FAM: begin
        rom_code_next           = {{(RomBits-8){1'b0}}, item.data.target_family};
        last_discrepancy_next   = RomBitsPos;
        last_family_disc_next   = '0;
        last_device_seen_next   = 1'b0;
        bit_position_next       = FirstPos;
        last_zero_position_next = '0;
        searching_next          = 1'b0;
        result_data_next.status = ST_RESET;
      end
      default: begin
        result_data_next.status = ST_IGNORED;
      end
    endcase

    result_data_next.family_discrepancy = last_family_disc_next;
  end

  // Advance search state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_code           <= '0;
      last_discrepancy   <= '0;
      last_family_disc   <= '0;
      last_device_seen   <= 1'b0;
      bit_position       <= FirstPos;
      last_zero_position <= '0;
      searching          <= 1'b0;
    end else if (accept) begin
      rom_code           <= rom_code_next;
      last_discrepancy   <= last_discrepancy_next;
      last_family_disc   <= last_family_disc_next;
      last_device_seen   <= last_device_seen_next;
      bit_position       <= bit_position_next;
      last_zero_position <= last_zero_position_next;
      searching          <= searching_next;
    end
  end

  // Hold the result until taken; load a new one on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= result_data_next;
    end
  end

  // Checks on the search state and results
  assert property (@(posedge clk) disable iff (rst)
    searching |-> (bit_position >= FirstPos && bit_position <= RomBitsPos))
    else $error("bit position out of range during a search");

  assert property (@(posedge clk) disable iff (rst)
    last_device_seen |-> !searching)
    else $error("search running after the last device was seen");

  assert property (@(posedge clk) disable iff (rst)
    last_family_disc < FamilyLimit[FamWidth-1:0])
    else $error("family discrepancy beyond the family code");

  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.status == ST_FOUND) |->
      (result.data.rom_address[7:0] != 8'd0))
    else $error("found address with zero family byte");

endmodule
